// File: rtl/suks_pkg.sv
// shared types and codes of the sorted unique key set
package suks_pkg;

    localparam int KEY_W = 64;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_ERASE  = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ABSENT    = 3'd4;

    localparam logic [3:0] REG_INVALID_KEY = 4'd0;

    typedef enum logic [1:0] {
        MV_HOLD  = 2'd0,
        MV_LEFT  = 2'd1,
        MV_RIGHT = 2'd2,
        MV_KEY   = 2'd3
    } mv_t;

    typedef struct packed {
        logic cmp_en;
        logic occ;
        mv_t  mv;
    } cell_ctl_t;

endpackage

// File: rtl/sorted_unique_key_set_top.sv
// top level of the sorted unique key set: control, cell chain and apb register
// The set keeps up to CAPACITY distinct 64-bit keys in ascending order in a row of cells,
// one key per cell. Each item passes two steps: in the compare step (S_CMP) every cell compares its key
// with the item's key and registers the result, in the apply step (S_APPLY) the chain shifts one place
// (insert or erase) and the result item is written to the output register. The next item
// is accepted during the apply step, so items stream with no idle state between them while
// results are taken; a result left waiting holds the second step of the following item.
// invalid_key sits at address 0 of the apb port and resets to all ones.
module sorted_unique_key_set_top
    import suks_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_kind,
    input  logic [KEY_W-1:0] s_key,
    input  logic [3:0]       s_position,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_status,
    output logic [3:0]       m_slot,
    output logic [KEY_W-1:0] m_element,
    output logic [4:0]       m_count,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int RD_N = (CAPACITY < 16) ? CAPACITY : 16;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [KEY_W-1:0] invalid_key_reg;
    logic [1:0]       op_kind_reg;
    logic [KEY_W-1:0] op_key_reg;
    logic [3:0]       op_pos_reg;

    logic             m_valid_reg, m_valid_next;
    logic [2:0]       m_status_reg, status_next;
    logic [3:0]       m_slot_reg, slot_next;
    logic [KEY_W-1:0] m_element_reg, element_next;
    logic [4:0]       m_count_reg;

    cell_ctl_t        ctl [CAPACITY];
    logic [KEY_W-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0] lt, eq, bnd;

    logic             in_acc, can_out, finish;
    logic             eq_hit;
    logic [3:0]       slot_found;
    logic [KEY_W-1:0] read_elem;
    logic             pos_ok;
    logic             do_insert, do_erase;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_W-1:0] left_in, right_in;
        if (i == 0) begin : g_first
            assign left_in = op_key_reg;
        end else begin : g_mid
            assign left_in = entry[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_in = entry[i];
        end else begin : g_inner
            assign right_in = entry[i+1];
        end
        suks_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl[i]),
            .key         (op_key_reg),
            .left_entry  (left_in),
            .right_entry (right_in),
            .entry       (entry[i]),
            .lt          (lt[i]),
            .eq          (eq[i])
        );
        if (i == 0) begin : g_b0
            assign bnd[i] = !lt[i];
        end else begin : g_bn
            assign bnd[i] = lt[i-1] && !lt[i];
        end
    end

    // boundary lookup and read select
    always_comb begin
        eq_hit     = 1'b0;
        slot_found = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (bnd[i]) begin
                slot_found = slot_found | 4'(i);
            end
            eq_hit = eq_hit | (bnd[i] & eq[i]);
        end
        read_elem = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (op_pos_reg == 4'(i)) begin
                read_elem = read_elem | entry[i];
            end
        end
    end

    assign pos_ok  = (32'(op_pos_reg) < 32'(count_reg)) && (32'(op_pos_reg) < CAPACITY);
    assign can_out = !m_valid_reg || m_ready;
    assign finish  = (state_reg == S_APPLY) && can_out;
    assign s_ready = (state_reg == S_IDLE) || finish;
    assign in_acc  = s_valid && s_ready;

    always_comb begin
        status_next  = ST_OK;
        slot_next    = '0;
        element_next = '0;
        do_insert    = 1'b0;
        do_erase     = 1'b0;
        case (op_kind_reg)
            KIND_INSERT: begin
                if (op_key_reg == invalid_key_reg) begin
                    status_next = ST_INVALID;
                end else if (eq_hit) begin
                    status_next = ST_DUPLICATE;
                end else if (32'(count_reg) >= CAPACITY) begin
                    status_next = ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    slot_next = slot_found;
                end
            end
            KIND_ERASE: begin
                if (eq_hit) begin
                    do_erase = 1'b1;
                end else begin
                    status_next = ST_ABSENT;
                end
            end
            KIND_FIND: begin
                if (eq_hit) begin
                    slot_next = slot_found;
                end else begin
                    status_next = ST_ABSENT;
                end
            end
            default: begin
                if (pos_ok) begin
                    element_next = read_elem;
                end else begin
                    element_next = invalid_key_reg;
                    status_next  = ST_ABSENT;
                end
            end
        endcase
        count_next = count_reg;
        if (do_insert) begin
            count_next = count_reg + CW'(1);
        end else if (do_erase) begin
            count_next = count_reg - CW'(1);
        end
    end

    // per-cell control
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            ctl[i].cmp_en = (state_reg == S_CMP);
            ctl[i].occ    = (32'(i) < 32'(count_reg));
            ctl[i].mv     = MV_HOLD;
            if (finish && do_insert) begin
                if (bnd[i]) begin
                    ctl[i].mv = MV_KEY;
                end else if (!lt[i]) begin
                    ctl[i].mv = MV_LEFT;
                end
            end else if (finish && do_erase) begin
                if (!lt[i]) begin
                    ctl[i].mv = MV_RIGHT;
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                state_next = S_APPLY;
            end
            S_APPLY: begin
                if (finish) begin
                    state_next = in_acc ? S_CMP : S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            m_valid_reg     <= 1'b0;
            invalid_key_reg <= '1;
        end else begin
            state_reg   <= state_next;
            count_reg   <= finish ? count_next : count_reg;
            m_valid_reg <= m_valid_next;
            if (psel && penable && pwrite && pready && (paddr[3] == REG_INVALID_KEY[3])) begin
                invalid_key_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            op_kind_reg <= s_kind;
            op_key_reg  <= s_key;
            op_pos_reg  <= s_position;
        end
        if (finish) begin
            m_status_reg  <= status_next;
            m_slot_reg    <= slot_next;
            m_element_reg <= element_next;
            m_count_reg   <= 5'(count_next);
        end
    end

    assign prdata    = (paddr[3] == REG_INVALID_KEY[3]) ? invalid_key_reg : 64'd0;
    assign pready    = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_slot    = m_slot_reg;
    assign m_element = m_element_reg;
    assign m_count   = m_count_reg;

endmodule

// File: rtl/suks_cell.sv
// one cell of the sorted chain: holds one key, compares it, shifts to its neighbors
module suks_cell
    import suks_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctl_t        ctl,
    input  logic [KEY_W-1:0] key,
    input  logic [KEY_W-1:0] left_entry,
    input  logic [KEY_W-1:0] right_entry,
    output logic [KEY_W-1:0] entry,
    output logic             lt,
    output logic             eq
);

    logic [KEY_W-1:0] entry_reg, entry_next;
    logic             lt_reg, lt_next;
    logic             eq_reg, eq_next;

    always_comb begin
        case (ctl.mv)
            MV_LEFT:  entry_next = left_entry;
            MV_RIGHT: entry_next = right_entry;
            MV_KEY:   entry_next = key;
            default:  entry_next = entry_reg;
        endcase
    end

    always_comb begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctl.cmp_en) begin
            lt_next = ctl.occ && (entry_reg < key);
            eq_next = ctl.occ && (entry_reg == key);
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end else begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

// File: rtl/suks_checker.sv
// port-level checker of the sorted unique key set and its bind
module suks_checker
    import suks_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [2:0]       m_status,
    input logic [3:0]       m_slot,
    input logic [KEY_W-1:0] m_element,
    input logic [4:0]       m_count
);

    // a result that waits stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item dropped while stalled");

    // an item needs its compare step before the next one is taken
    a_no_back_to_back: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input item taken in the compare cycle");

    // rejected inserts (invalid, duplicate, full) carry no slot and no element
    a_reject_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_INVALID || m_status == ST_DUPLICATE ||
                    m_status == ST_FULL)
        |-> (m_slot == 4'd0) && (m_element == '0))
        else $error("rejected item carries slot or element");

    // count stays within capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (CAPACITY < 32) |-> (32'(m_count) <= CAPACITY))
        else $error("count beyond capacity");

endmodule

bind sorted_unique_key_set_top suks_checker #(.CAPACITY(CAPACITY)) u_suks_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_status  (m_status),
    .m_slot    (m_slot),
    .m_element (m_element),
    .m_count   (m_count)
);
